// ===== hdl/lirr_pkg.sv =====
// ----------------------------------------------------------------------------
// Linear interpolation resampler package
// Shared constants, register codes and the control word of the shared
// multiplier.
// ----------------------------------------------------------------------------
package lirr_pkg;

   localparam int SAMPLE_WIDTH_DEF = 16;
   localparam int PHASE_WIDTH_DEF  = 16;
   localparam int MAX_RUN_DEF      = 64;

   localparam int INV_WIDTH  = 32;
   localparam int FRAC_WIDTH = 17;
   localparam int OPB_WIDTH  = FRAC_WIDTH + 1;

   localparam logic [FRAC_WIDTH-1:0] FRAC_ONE  = 17'h10000;
   localparam logic [15:0]           FRAC_HALF = 16'h8000;

   localparam int CSR_DATA_WIDTH = 32;
   localparam int CSR_ADDR_WIDTH = 4;

   localparam logic [1:0] REG_MODULUS_M = 2'd0;
   localparam logic [1:0] REG_STEP_N    = 2'd1;
   localparam logic [1:0] REG_INV_M     = 2'd2;

   localparam logic [INV_WIDTH-1:0] INV_M_RESET = 32'hFFFF_FFFF;

   typedef enum logic [1:0] {
      MUL_LO,
      MUL_HI,
      MUL_DIFF
   } mul_op_type;

   typedef struct packed {
      logic       enable;
      mul_op_type op;
   } mul_ctrl_type;

   function automatic int mul_a_width(input int sample_width, input int phase_width);
      int w;
      w = (phase_width + 2 > sample_width + 1) ? phase_width + 2 : sample_width + 1;
      return w;
   endfunction

endpackage

// ===== hdl/linear_interp_rational_resampler.sv =====
// Each output word takes three products from the single shared multiplier;
// the input is stalled until the block has finished every word of the
// current sample, and also while it checks a sample that gives no word.
// Reset is synchronous: M = 1, N = 1, reciprocal all ones, phase and the
// previous sample cleared.
// ----------------------------------------------------------------------------
// Linear interpolation rational resampler
// Rational rate M/N resampler that interpolates linearly between the
// previous and the current sample, with a register port for M, N and 1/M.
// ----------------------------------------------------------------------------
module linear_interp_rational_resampler #(
   parameter int SAMPLE_WIDTH = lirr_pkg::SAMPLE_WIDTH_DEF,
   parameter int PHASE_WIDTH  = lirr_pkg::PHASE_WIDTH_DEF,
   parameter int MAX_RUN      = lirr_pkg::MAX_RUN_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [SAMPLE_WIDTH-1:0]       req_sample,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [SAMPLE_WIDTH-1:0]       rsp_out_sample,
   output logic                                 rsp_last,
   output logic                                 rsp_overrun,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [lirr_pkg::CSR_ADDR_WIDTH-1:0]  csr_paddr,
   input  logic [lirr_pkg::CSR_DATA_WIDTH-1:0]  csr_pwdata,
   output logic [lirr_pkg::CSR_DATA_WIDTH-1:0]  csr_prdata,
   output logic                                 csr_pready
);
   import lirr_pkg::*;

   localparam int PROD_WIDTH = mul_a_width(SAMPLE_WIDTH, PHASE_WIDTH) + OPB_WIDTH;

   logic [PHASE_WIDTH-1:0]        modulus_m;
   logic [PHASE_WIDTH-1:0]        step_n;
   logic [INV_WIDTH-1:0]          inv_m;
   mul_ctrl_type                  mul_ctrl;
   logic [PHASE_WIDTH:0]          mul_phase;
   logic signed [SAMPLE_WIDTH:0]  mul_diff;
   logic [FRAC_WIDTH-1:0]         mul_frac;
   logic signed [PROD_WIDTH-1:0]  mul_product;

   lirr_csr #(
      .PHASE_WIDTH (PHASE_WIDTH)
   ) u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .modulus_m   (modulus_m),
      .step_n      (step_n),
      .inv_m       (inv_m)
   );

   lirr_mul #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .PHASE_WIDTH  (PHASE_WIDTH),
      .PROD_WIDTH   (PROD_WIDTH)
   ) u_mul (
      .clock   (clock),
      .ctrl    (mul_ctrl),
      .phase   (mul_phase),
      .diff    (mul_diff),
      .frac    (mul_frac),
      .inv_m   (inv_m),
      .product (mul_product)
   );

   lirr_core #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .PHASE_WIDTH  (PHASE_WIDTH),
      .MAX_RUN      (MAX_RUN),
      .PROD_WIDTH   (PROD_WIDTH)
   ) u_core (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_sample     (req_sample),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_sample (rsp_out_sample),
      .rsp_last       (rsp_last),
      .rsp_overrun    (rsp_overrun),
      .modulus_m      (modulus_m),
      .step_n         (step_n),
      .mul_ctrl       (mul_ctrl),
      .mul_phase      (mul_phase),
      .mul_diff       (mul_diff),
      .mul_frac       (mul_frac),
      .mul_product    (mul_product)
   );

endmodule

// ===== hdl/lirr_csr.sv =====
// ----------------------------------------------------------------------------
// Resampler register file
// Holds the modulus, the step and the reciprocal of the modulus, written
// and read over the register port.
// ----------------------------------------------------------------------------
module lirr_csr #(
   parameter int PHASE_WIDTH = lirr_pkg::PHASE_WIDTH_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [lirr_pkg::CSR_ADDR_WIDTH-1:0]   csr_paddr,
   input  logic [lirr_pkg::CSR_DATA_WIDTH-1:0]   csr_pwdata,
   output logic [lirr_pkg::CSR_DATA_WIDTH-1:0]   csr_prdata,
   output logic                                  csr_pready,
   output logic [PHASE_WIDTH-1:0]                modulus_m,
   output logic [PHASE_WIDTH-1:0]                step_n,
   output logic [lirr_pkg::INV_WIDTH-1:0]        inv_m
);
   import lirr_pkg::*;

   logic [PHASE_WIDTH-1:0] modulus_m_ff;
   logic [PHASE_WIDTH-1:0] step_n_ff;
   logic [INV_WIDTH-1:0]   inv_m_ff;
   logic                   write_en;
   logic [1:0]             reg_index;

   assign write_en  = csr_psel && csr_penable && csr_pwrite;
   assign reg_index = csr_paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_m_ff <= PHASE_WIDTH'(1);
         step_n_ff    <= PHASE_WIDTH'(1);
         inv_m_ff     <= INV_M_RESET;
      end else if (write_en) begin
         unique case (reg_index)
            REG_MODULUS_M: modulus_m_ff <= csr_pwdata[PHASE_WIDTH-1:0];
            REG_STEP_N:    step_n_ff    <= csr_pwdata[PHASE_WIDTH-1:0];
            REG_INV_M:     inv_m_ff     <= csr_pwdata[INV_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_index)
         REG_MODULUS_M: csr_prdata = CSR_DATA_WIDTH'(modulus_m_ff);
         REG_STEP_N:    csr_prdata = CSR_DATA_WIDTH'(step_n_ff);
         REG_INV_M:     csr_prdata = CSR_DATA_WIDTH'(inv_m_ff);
         default:       csr_prdata = '0;
      endcase
   end

   assign csr_pready = 1'b1;
   assign modulus_m  = modulus_m_ff;
   assign step_n     = step_n_ff;
   assign inv_m      = inv_m_ff;

endmodule

// ===== hdl/lirr_mul.sv =====
// ----------------------------------------------------------------------------
// Resampler shared multiplier
// One registered signed multiplier whose operands are chosen by the
// sequencer: phase by either half of the reciprocal, or difference by
// fraction.
// ----------------------------------------------------------------------------
module lirr_mul #(
   parameter int SAMPLE_WIDTH = lirr_pkg::SAMPLE_WIDTH_DEF,
   parameter int PHASE_WIDTH  = lirr_pkg::PHASE_WIDTH_DEF,
   parameter int PROD_WIDTH   = lirr_pkg::mul_a_width(SAMPLE_WIDTH, PHASE_WIDTH)
                                + lirr_pkg::OPB_WIDTH
) (
   input  logic                                 clock,
   input  lirr_pkg::mul_ctrl_type               ctrl,
   input  logic [PHASE_WIDTH:0]                 phase,
   input  logic signed [SAMPLE_WIDTH:0]         diff,
   input  logic [lirr_pkg::FRAC_WIDTH-1:0]      frac,
   input  logic [lirr_pkg::INV_WIDTH-1:0]       inv_m,
   output logic signed [PROD_WIDTH-1:0]         product
);
   import lirr_pkg::*;

   localparam int AW = PROD_WIDTH - OPB_WIDTH;

   logic signed [AW-1:0]         opa;
   logic signed [OPB_WIDTH-1:0]  opb;
   logic signed [PROD_WIDTH-1:0] product_ff;

   always_comb begin
      unique case (ctrl.op)
         MUL_LO: begin
            opa = AW'($signed({1'b0, phase}));
            opb = $signed({2'b00, inv_m[15:0]});
         end
         MUL_HI: begin
            opa = AW'($signed({1'b0, phase}));
            opb = $signed({2'b00, inv_m[31:16]});
         end
         MUL_DIFF: begin
            opa = AW'(diff);
            opb = $signed({1'b0, frac});
         end
         default: begin
            opa = '0;
            opb = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (ctrl.enable) begin
         product_ff <= opa * opb;
      end
   end

   assign product = product_ff;

endmodule

// ===== hdl/lirr_core.sv =====
// ----------------------------------------------------------------------------
// Resampler sequencer
// Keeps phase and previous sample, steps the shared multiplier through
// the three products of each output word and holds the output register.
// ----------------------------------------------------------------------------
module lirr_core #(
   parameter int SAMPLE_WIDTH = lirr_pkg::SAMPLE_WIDTH_DEF,
   parameter int PHASE_WIDTH  = lirr_pkg::PHASE_WIDTH_DEF,
   parameter int MAX_RUN      = lirr_pkg::MAX_RUN_DEF,
   parameter int PROD_WIDTH   = lirr_pkg::mul_a_width(SAMPLE_WIDTH, PHASE_WIDTH)
                                + lirr_pkg::OPB_WIDTH
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic signed [SAMPLE_WIDTH-1:0]     req_sample,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [SAMPLE_WIDTH-1:0]     rsp_out_sample,
   output logic                               rsp_last,
   output logic                               rsp_overrun,
   input  logic [PHASE_WIDTH-1:0]             modulus_m,
   input  logic [PHASE_WIDTH-1:0]             step_n,
   output lirr_pkg::mul_ctrl_type             mul_ctrl,
   output logic [PHASE_WIDTH:0]               mul_phase,
   output logic signed [SAMPLE_WIDTH:0]       mul_diff,
   output logic [lirr_pkg::FRAC_WIDTH-1:0]    mul_frac,
   input  logic signed [PROD_WIDTH-1:0]       mul_product
);
   import lirr_pkg::*;

   localparam int CW = $clog2(MAX_RUN + 1);
   localparam int SW = SAMPLE_WIDTH;
   localparam int PW = PHASE_WIDTH;

   typedef enum logic [2:0] {
      S_IDLE,
      S_CHECK,
      S_HI,
      S_FRAC,
      S_DIFF,
      S_EMIT
   } state_type;

   state_type              state_ff, state_in;
   logic [PW:0]            phase_ff, phase_in;
   logic signed [SW-1:0]   prev_ff, prev_in;
   logic signed [SW-1:0]   curr_ff, curr_in;
   logic signed [SW:0]     diff_ff, diff_in;
   logic [CW-1:0]          count_ff, count_in;
   logic [PW:0]            lo_part_ff, lo_part_in;
   logic [FRAC_WIDTH-1:0]  frac_ff, frac_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic signed [SW-1:0]   rsp_sample_ff, rsp_sample_in;
   logic                   rsp_last_ff, rsp_last_in;
   logic                   rsp_overrun_ff, rsp_overrun_in;

   logic [PW:0]            m_ext;
   logic [PW:0]            phase_next;
   logic [CW-1:0]          count_next;
   logic                   run_cut;
   logic                   out_free;
   logic [PW+17:0]         frac_sum;
   logic [PROD_WIDTH-1:0]  rnd_sum;
   logic signed [SW+1:0]   delta;
   logic signed [SW+2:0]   sum_wide;
   logic signed [SW-1:0]   sample_sat;

   assign m_ext      = {1'b0, modulus_m};
   assign phase_next = phase_ff + (PW+1)'(step_n);
   assign count_next = count_ff + CW'(1);
   assign run_cut    = (count_next == CW'(MAX_RUN));
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign frac_sum   = (PW+18)'(mul_product[PW+16:0]) + (PW+18)'(lo_part_ff);
   assign rnd_sum    = mul_product + PROD_WIDTH'(FRAC_HALF);
   assign delta      = $signed(rnd_sum[SW+17:16]);
   assign sum_wide   = $signed({{3{prev_ff[SW-1]}}, prev_ff}) + $signed({delta[SW+1], delta});

   always_comb begin
      if ((sum_wide[SW+2:SW-1] == '0) || (sum_wide[SW+2:SW-1] == '1)) begin
         sample_sat = sum_wide[SW-1:0];
      end else if (sum_wide[SW+2]) begin
         sample_sat = $signed({1'b1, {(SW-1){1'b0}}});
      end else begin
         sample_sat = $signed({1'b0, {(SW-1){1'b1}}});
      end
   end

   always_comb begin
      state_in        = state_ff;
      phase_in        = phase_ff;
      prev_in         = prev_ff;
      curr_in         = curr_ff;
      diff_in         = diff_ff;
      count_in        = count_ff;
      lo_part_in      = lo_part_ff;
      frac_in         = frac_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_sample_in   = rsp_sample_ff;
      rsp_last_in     = rsp_last_ff;
      rsp_overrun_in  = rsp_overrun_ff;
      mul_ctrl.enable = 1'b0;
      mul_ctrl.op     = MUL_LO;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               curr_in  = req_sample;
               diff_in  = $signed({req_sample[SW-1], req_sample})
                        - $signed({prev_ff[SW-1], prev_ff});
               count_in = '0;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (phase_ff < m_ext) begin
               mul_ctrl.enable = 1'b1;
               mul_ctrl.op     = MUL_LO;
               state_in        = S_HI;
            end else begin
               phase_in = phase_ff - m_ext;
               prev_in  = curr_ff;
               state_in = S_IDLE;
            end
         end
         S_HI: begin
            mul_ctrl.enable = 1'b1;
            mul_ctrl.op     = MUL_HI;
            lo_part_in      = mul_product[PW+16:16];
            state_in        = S_FRAC;
         end
         S_FRAC: begin
            if (frac_sum > (PW+18)'(FRAC_ONE)) begin
               frac_in = FRAC_ONE;
            end else begin
               frac_in = frac_sum[FRAC_WIDTH-1:0];
            end
            state_in = S_DIFF;
         end
         S_DIFF: begin
            mul_ctrl.enable = 1'b1;
            mul_ctrl.op     = MUL_DIFF;
            state_in        = S_EMIT;
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_sample_in = sample_sat;
               priority if (phase_next >= m_ext) begin
                  rsp_last_in    = 1'b1;
                  rsp_overrun_in = 1'b0;
                  phase_in       = phase_next - m_ext;
                  prev_in        = curr_ff;
                  state_in       = S_IDLE;
               end else if (run_cut) begin
                  rsp_last_in    = 1'b1;
                  rsp_overrun_in = 1'b1;
                  phase_in       = '0;
                  prev_in        = curr_ff;
                  state_in       = S_IDLE;
               end else begin
                  rsp_last_in    = 1'b0;
                  rsp_overrun_in = 1'b0;
                  phase_in       = phase_next;
                  count_in       = count_next;
                  state_in       = S_CHECK;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         phase_ff     <= '0;
         prev_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         prev_ff      <= prev_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      curr_ff        <= curr_in;
      diff_ff        <= diff_in;
      lo_part_ff     <= lo_part_in;
      frac_ff        <= frac_in;
      rsp_sample_ff  <= rsp_sample_in;
      rsp_last_ff    <= rsp_last_in;
      rsp_overrun_ff <= rsp_overrun_in;
   end

   assign req_stall      = (state_ff != S_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_sample = rsp_sample_ff;
   assign rsp_last       = rsp_last_ff;
   assign rsp_overrun    = rsp_overrun_ff;
   assign mul_phase      = phase_ff;
   assign mul_diff       = diff_ff;
   assign mul_frac       = frac_ff;

`ifndef NO_ASSERTIONS
   a_overrun_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_overrun_ff) |-> rsp_last_ff)
      else $error("overrun flagged on a word that is not the last");

   a_run_bounded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CHECK) |-> (count_ff < CW'(MAX_RUN)))
      else $error("run count reached its limit before a result check");

   a_frac_bounded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIFF) |-> (frac_ff <= FRAC_ONE))
      else $error("fraction above one at the final product");

   a_end_word_last: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMIT && state_in == S_IDLE) |=> (rsp_valid_ff && rsp_last_ff))
      else $error("run ended without a last word");
`endif

endmodule

// ===== verif/linear_interp_rational_resampler_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Linear interpolation rational resampler testbench
// Drives samples and register writes into the resampler and checks every
// output word against a cycle-free prediction of the interpolation, the
// phase count, the run cut and its overrun flag. Both channels idle and
// stall at random, and one stretch holds the output back until the input
// backs up.
// ----------------------------------------------------------------------------
module linear_interp_rational_resampler_test;

   import lirr_pkg::*;

   localparam int  SW           = SAMPLE_WIDTH_DEF;
   localparam int  PW           = PHASE_WIDTH_DEF;
   localparam int  RUN_LIMIT    = MAX_RUN_DEF;
   localparam int  SETTLE       = 12;
   localparam int  HOLD_CYCLES  = 600;
   localparam int  LIMIT_CYCLES = 2_000_000;
   localparam int  PHASES       = 10;

   typedef enum int {
      CFG_UP_SMALL,
      CFG_UP_MID,
      CFG_DOWN,
      CFG_UP_LARGE,
      CFG_OVERRUN,
      CFG_EQUAL
   } cfg_kind_type;

   typedef struct {
      logic signed [SW-1:0] out_sample;
      logic                 last;
      logic                 overrun;
   } resampler_word_type;

   class resampler_scoreboard;
      bit [PW-1:0]          mod_m;
      bit [PW-1:0]          step;
      bit [31:0]            inv;
      bit [PW:0]            phase;
      logic signed [SW-1:0] prev;
      resampler_word_type   expected_q[$];
      int                   errors;

      function new();
         mod_m  = 1;
         step   = 1;
         inv    = INV_M_RESET;
         phase  = '0;
         prev   = '0;
         errors = 0;
      endfunction

      function void write_reg(logic [1:0] index, logic [31:0] value);
         case (index)
            REG_MODULUS_M: mod_m = value[PW-1:0];
            REG_STEP_N:    step  = value[PW-1:0];
            REG_INV_M:     inv   = value;
            default: ;
         endcase
      endfunction

      function logic signed [SW-1:0] interpolate(logic signed [SW-1:0] a,
                                                 logic signed [SW-1:0] b,
                                                 bit [PW:0] ph);
         longint unsigned frac;
         longint          diff;
         longint          r;
         frac = longint'(ph) * (inv >> 16) + ((longint'(ph) * (inv & 32'hFFFF)) >> 16);
         if (frac > 65536)
            frac = 65536;
         diff = longint'(b) - longint'(a);
         r = longint'(a) + ((diff * $signed(frac) + 32768) >>> 16);
         if (r > 32767)
            r = 32767;
         if (r < -32768)
            r = -32768;
         return r[SW-1:0];
      endfunction

      function void note_sample(logic signed [SW-1:0] curr);
         int                 count;
         bit                 cut;
         resampler_word_type w;
         count = 0;
         cut   = 0;
         while (phase < mod_m && count < RUN_LIMIT) begin
            w.out_sample = interpolate(prev, curr, phase);
            w.last       = 1'b0;
            w.overrun    = 1'b0;
            expected_q.push_back(w);
            count++;
            phase = phase + step;
         end
         if (phase < mod_m) begin
            cut   = 1;
            phase = '0;
         end else begin
            phase = phase - mod_m;
         end
         if (count > 0) begin
            w = expected_q.pop_back();
            w.last    = 1'b1;
            w.overrun = cut;
            expected_q.push_back(w);
         end
         prev = curr;
      endfunction

      function void check_word(logic signed [SW-1:0] out_sample, logic last,
                               logic overrun);
         resampler_word_type w;
         if (expected_q.size() == 0) begin
            $error("unexpected word: out_sample %0d last %0b overrun %0b",
                   out_sample, last, overrun);
            errors++;
            return;
         end
         w = expected_q.pop_front();
         if (out_sample !== w.out_sample) begin
            $error("out_sample: expected %0d, actual %0d", w.out_sample, out_sample);
            errors++;
         end
         if (last !== w.last) begin
            $error("last: expected %0b, actual %0b", w.last, last);
            errors++;
         end
         if (overrun !== w.overrun) begin
            $error("overrun: expected %0b, actual %0b", w.overrun, overrun);
            errors++;
         end
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic                       clock;
   logic                       reset       = 1'b1;
   logic                       req_valid   = 1'b0;
   logic                       req_stall;
   logic signed [SW-1:0]       req_sample  = '0;
   logic                       rsp_valid;
   logic                       rsp_stall   = 1'b0;
   logic signed [SW-1:0]       rsp_out_sample;
   logic                       rsp_last;
   logic                       rsp_overrun;
   logic                       csr_psel    = 1'b0;
   logic                       csr_penable = 1'b0;
   logic                       csr_pwrite  = 1'b0;
   logic [CSR_ADDR_WIDTH-1:0]  csr_paddr   = '0;
   logic [CSR_DATA_WIDTH-1:0]  csr_pwdata  = '0;
   logic [CSR_DATA_WIDTH-1:0]  csr_prdata;
   logic                       csr_pready;

   resampler_scoreboard sb;
   int  send_idle_pct = 0;
   int  rsp_stall_pct = 0;
   bit  hold_armed    = 1'b0;
   int  hold_left     = HOLD_CYCLES;
   int  cycle_count   = 0;

   linear_interp_rational_resampler u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_sample     (req_sample),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_sample (rsp_out_sample),
      .rsp_last       (rsp_last),
      .rsp_overrun    (rsp_overrun),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("linear_interp_rational_resampler_test: done, errors");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall)
            sb.check_word(rsp_out_sample, rsp_last, rsp_overrun);
         if (hold_armed && hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left <= hold_left - 1;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < rsp_stall_pct);
         end
      end
   end

   task automatic csr_write(logic [1:0] index, logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      sb.write_reg(index, value);
   endtask

   task automatic send_sample(logic signed [SW-1:0] s);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_sample <= s;
      do @(posedge clock); while (req_stall);
      sb.note_sample(s);
   endtask

   // The wait after the last word covers samples that give no word but are
   // still moving the phase on inside the block.
   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending() > 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic set_rate(logic [PW-1:0] m, logic [PW-1:0] n, logic [31:0] inv);
      drain();
      csr_write(REG_MODULUS_M, {16'h0, m});
      csr_write(REG_STEP_N, {16'h0, n});
      csr_write(REG_INV_M, inv);
   endtask

   function automatic logic [31:0] reciprocal(logic [PW-1:0] m);
      longint unsigned q;
      if (m == 0)
         return 32'hFFFF_FFFF;
      q = 64'h1_0000_0000 / m;
      return (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
   endfunction

   function automatic logic signed [SW-1:0] random_sample();
      case ($urandom_range(0, 3))
         0:       return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
         1:       return $signed(16'($urandom_range(0, 64))) - 16'sd32;
         default: return 16'($urandom);
      endcase
   endfunction

   initial begin
      logic [PW-1:0] m;
      logic [PW-1:0] n;
      logic [31:0]   inv;
      cfg_kind_type  kind;
      int            items;

      sb = new();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset rates: each sample gives one word, the previous sample.
      send_sample(16'sh7FFF);
      send_sample(16'sh8000);
      send_sample(16'sh0000);
      send_sample(-16'sd1);
      send_sample(16'sd1);

      // Fourfold upsampling across full-scale steps.
      set_rate(16'd4, 16'd1, reciprocal(16'd4));
      send_sample(16'sh8000);
      send_sample(16'sh7FFF);
      send_sample(16'sh8000);

      set_rate(16'd3, 16'd2, reciprocal(16'd3));
      send_sample(16'sd1);
      send_sample(-16'sd2);
      send_sample(16'sd3);
      send_sample(16'sh7FFF);

      // A zero step never leaves the run, so it is cut and flagged.
      drain();
      csr_write(REG_STEP_N, 32'd0);
      send_sample(16'sd100);
      send_sample(-16'sd100);

      set_rate(16'hFFFF, 16'd1, reciprocal(16'hFFFF));
      send_sample(16'sh4000);

      // Downsampling leaves the phase high; lowering M then finds the
      // phase at or above it, and raising M again with a stale reciprocal
      // drives the fraction into saturation.
      set_rate(16'd100, 16'd1000, reciprocal(16'd100));
      send_sample(16'sd5);
      send_sample(16'sd6);
      set_rate(16'd10, 16'd3, reciprocal(16'd10));
      send_sample(-16'sd7);
      send_sample(16'sd8);
      drain();
      csr_write(REG_MODULUS_M, 32'd1000);
      send_sample(16'sh1234);

      // With M at zero no word comes and the phase stands still.
      drain();
      csr_write(REG_MODULUS_M, 32'd0);
      send_sample(16'sh7FFF);
      send_sample(16'sh8000);

      for (int p = 0; p < PHASES; p++) begin
         kind = cfg_kind_type'(p % 6);
         case (kind)
            CFG_UP_SMALL: begin
               m = PW'($urandom_range(1, 16));
               n = PW'($urandom_range(1, m));
            end
            CFG_UP_MID: begin
               m = PW'($urandom_range(100, 5000));
               n = PW'(m / $urandom_range(1, 8));
            end
            CFG_DOWN: begin
               m = PW'($urandom_range(1, 1000));
               n = PW'($urandom_range(m, 4 * m));
            end
            CFG_UP_LARGE: begin
               m = PW'($urandom_range(30000, 65535));
               n = PW'(m / $urandom_range(1, 4));
            end
            CFG_OVERRUN: begin
               m = 16'hFFFF;
               n = PW'($urandom_range(1, 500));
            end
            default: begin
               m = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom_range(1, 65535));
               n = m;
            end
         endcase
         inv = ($urandom_range(0, 7) == 0) ? 32'($urandom) : reciprocal(m);
         set_rate(m, n, inv);

         case (p % 4)
            0: begin
               send_idle_pct <= 0;
               rsp_stall_pct <= 0;
            end
            1: begin
               send_idle_pct <= 80;
               rsp_stall_pct <= 0;
            end
            2: begin
               send_idle_pct <= 0;
               rsp_stall_pct <= 80;
            end
            default: begin
               send_idle_pct <= 11;
               rsp_stall_pct <= 11;
            end
         endcase
         if (p == 4) begin
            hold_armed <= 1'b1;
         end

         items = (kind == CFG_OVERRUN) ? 6 : 26;
         for (int i = 0; i < items; i++)
            send_sample(random_sample());
      end

      drain();
      repeat (20) @(posedge clock);
      if (sb.errors == 0)
         $display("linear_interp_rational_resampler_test: done, clean");
      else
         $display("linear_interp_rational_resampler_test: done, errors");
      $finish;
   end

endmodule

// ===== files.f =====
hdl/lirr_pkg.sv
hdl/lirr_csr.sv
hdl/lirr_mul.sv
hdl/lirr_core.sv
hdl/linear_interp_rational_resampler.sv
verif/linear_interp_rational_resampler_test.sv
